FILE: rtl/core/sorted_row_order_checker_macros.svh
// Assertion macros shared by the sorted row order checker RTL.
// Depends on nothing; the including module must have aclk and aresetn.
`ifndef SORTED_ROW_ORDER_CHECKER_MACROS_SVH
`define SORTED_ROW_ORDER_CHECKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SROC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sorted_row_order_checker: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SROC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sorted_row_order_checker: next-cycle check failed");

`endif

FILE: rtl/core/sroc_pkg.sv
// Types and constants for the sorted row order checker.
// No dependencies; imported by sroc_row_cmp and sorted_row_order_checker.
`default_nettype none

package sroc_pkg;

    localparam int KEY_W      = 64;
    localparam int KEY_FIELDS = 4;
    localparam int MAX_KEYS   = 4;
    // Keys beyond either bound are never compared.
    localparam int KEY_LIMIT  = (MAX_KEYS < KEY_FIELDS) ? MAX_KEYS : KEY_FIELDS;

    localparam int CFG_DATA_W = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int DEC_W      = 3;

    localparam logic [DEC_W-1:0] ALL_EQUAL = 3'd4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_KEY_COUNT       = 2'd0,
        REG_DESCENDING_MASK = 2'd1,
        REG_NULLS_FIRST     = 2'd2
    } cfg_reg_t;

    typedef logic [KEY_FIELDS-1:0][KEY_W-1:0] row_keys_t;
    typedef logic [KEY_FIELDS-1:0]            null_mask_t;

    typedef struct packed {
        logic [2:0]            key_count;
        logic [KEY_FIELDS-1:0] descending_mask;
        logic                  nulls_first;
    } cfg_t;

    typedef struct packed {
        logic              order_error;
        logic [DEC_W-1:0]  deciding_key;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/sroc_row_cmp.sv
// Row comparator: compares a new row against the stored previous row,
// key by key in priority order. Uses sroc_pkg.
`default_nettype none

module sroc_row_cmp
    import sroc_pkg::*;
(
    input  wire cfg_t       cfg,
    input  wire logic       have_previous,
    input  wire row_keys_t  prev_keys,
    input  wire null_mask_t prev_nulls,
    input  wire row_keys_t  cur_keys,
    input  wire null_mask_t cur_nulls,
    output result_t         res
);

    logic [KEY_FIELDS-1:0] key_active;
    logic [KEY_FIELDS-1:0] key_diff;
    logic [KEY_FIELDS-1:0] key_err;

    for (genvar g = 0; g < KEY_FIELDS; g++) begin : g_key
        logic prev_lt;
        logic prev_gt;

        assign key_active[g] = (g < KEY_LIMIT) && (cfg.key_count > 3'(g));
        assign prev_lt = $signed(prev_keys[g]) < $signed(cur_keys[g]);
        assign prev_gt = $signed(cur_keys[g]) < $signed(prev_keys[g]);

        always_comb begin
            if (prev_nulls[g] && cur_nulls[g]) begin
                key_diff[g] = 1'b0;
                key_err[g]  = 1'b0;
            end else if (prev_nulls[g]) begin
                key_diff[g] = 1'b1;
                key_err[g]  = ~cfg.nulls_first;
            end else if (cur_nulls[g]) begin
                key_diff[g] = 1'b1;
                key_err[g]  = cfg.nulls_first;
            end else if (prev_lt) begin
                key_diff[g] = 1'b1;
                key_err[g]  = cfg.descending_mask[g];
            end else begin
                key_diff[g] = prev_gt;
                key_err[g]  = prev_gt & ~cfg.descending_mask[g];
            end
        end
    end

    // Walk from the lowest priority up so the highest-priority difference wins.
    always_comb begin
        res.order_error  = 1'b0;
        res.deciding_key = ALL_EQUAL;
        if (have_previous) begin
            for (int i = KEY_FIELDS - 1; i >= 0; i--) begin
                if (key_active[i] && key_diff[i]) begin
                    res.order_error  = key_err[i];
                    res.deciding_key = DEC_W'(i);
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_row_order_checker.sv
// Top level of the sorted row order checker: configuration registers,
// previous-row store, output register with skid. Uses sroc_pkg, sroc_row_cmp
// and sorted_row_order_checker_macros.svh.
//
//  channel | direction | payload
//  --------+-----------+------------------------------------------------
//  s_      | in        | tdata: key_a..key_d, tuser: null_mask
//  m_      | out       | tdata: order_error, deciding_key
//  cfg_    | in        | we, addr, wdata (write only)
//
// One row is taken every cycle while s_tready is high; its result is registered when the row is taken.
// The comparison of four 64-bit keys against the stored row sets the path.
// A two-entry output (result register plus skid) keeps s_tready high while
// one result waits; s_tready drops only when both entries are full or reset is held.
// Reset is synchronous, active low, and clears all control state and the
// stored null mask; no row is taken while reset is held.
`default_nettype none

`include "sorted_row_order_checker_macros.svh"

module sorted_row_order_checker
    import sroc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [63:0] key_a, [127:64] key_b, [191:128] key_c, [255:192] key_d
    input  wire logic [255:0]          s_tdata,
    // [3:0] null_mask
    input  wire logic [3:0]            s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] order_error, [3:1] deciding_key, [7:4] zero
    output logic [7:0]                 m_tdata,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t       cfg_reg;
    row_keys_t  prev_keys_reg;
    null_mask_t prev_nulls_reg;
    logic       have_previous_reg;

    result_t    out_data_reg;
    logic       out_valid_reg;
    result_t    skid_data_reg;
    logic       skid_valid_reg;

    row_keys_t  cur_keys;
    result_t    cmp_res;
    logic       accept;
    logic       pop;

    assign cur_keys = s_tdata;
    assign s_tready = aresetn && !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg.deciding_key, out_data_reg.order_error};

    sroc_row_cmp u_row_cmp (
        .cfg           (cfg_reg),
        .have_previous (have_previous_reg),
        .prev_keys     (prev_keys_reg),
        .prev_nulls    (prev_nulls_reg),
        .cur_keys      (cur_keys),
        .cur_nulls     (s_tuser),
        .res           (cmp_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.key_count       <= 3'd1;
            cfg_reg.descending_mask <= '0;
            cfg_reg.nulls_first     <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                REG_KEY_COUNT:       cfg_reg.key_count       <= cfg_wdata[2:0];
                REG_DESCENDING_MASK: cfg_reg.descending_mask <= cfg_wdata[KEY_FIELDS-1:0];
                REG_NULLS_FIRST:     cfg_reg.nulls_first     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Previous row store; key values need no reset since have_previous guards them.
    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_keys_reg <= cur_keys;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_nulls_reg    <= '0;
            have_previous_reg <= 1'b0;
        end else if (accept) begin
            prev_nulls_reg    <= s_tuser;
            have_previous_reg <= 1'b1;
        end
    end

    // Output register and skid. A new result goes to the skid entry only when
    // the output register is full and not being drained this cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_data_reg  <= cmp_res;
                out_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= cmp_res;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    `SROC_ASSERT_IMPL(a_skid_implies_out, skid_valid_reg, out_valid_reg)
    `SROC_ASSERT_IMPL(a_first_row_clean, !have_previous_reg, !cmp_res.order_error && cmp_res.deciding_key == ALL_EQUAL)
    `SROC_ASSERT_IMPL(a_error_has_key, cmp_res.order_error, cmp_res.deciding_key != ALL_EQUAL)
    `SROC_ASSERT_NEXT(a_accept_stores_row, accept, have_previous_reg && out_valid_reg)

endmodule

`default_nettype wire

FILE: sim/tb_sorted_row_order_checker.sv
// Self-checking testbench for sorted_row_order_checker: streams rows with random stalls on
// both sides and compares each verdict against a behavioral order predictor.
// Depends on sroc_pkg and the checker RTL only.
module tb_sorted_row_order_checker;
    import sroc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int PHASE_ROWS     = 225;
    localparam int RANDOM_PHASES  = 8;
    localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct {
        row_keys_t  keys;
        null_mask_t nulls;
    } row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata  = '0;
    logic [3:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;

    logic                  cfg_we    = 1'b0;
    cfg_reg_t              cfg_addr  = REG_KEY_COUNT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor state: register copies and the stored row.
    logic [2:0]            cur_key_count   = 3'd1;
    logic [KEY_FIELDS-1:0] cur_desc_mask   = '0;
    logic                  cur_nulls_first = 1'b0;
    row_keys_t             stored_keys;
    null_mask_t            stored_nulls = '0;
    logic                  seen_row     = 1'b0;

    row_t    rows_to_send[$];
    result_t expected_verdicts[$];
    row_t    offered_row;
    row_t    last_row;

    int rows_issued     = 0;
    int verdicts_seen   = 0;
    int fail_count      = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int holdoff_left    = 0;
    int quiet_cycles    = 0;

    sorted_row_order_checker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // -1: previous row is ahead on this key, 1: new row is out of order, 0: tie.
    function automatic int key_step_order(int idx, logic signed [KEY_W-1:0] prev, logic prev_null,
                                          logic signed [KEY_W-1:0] cur, logic cur_null);
        logic desc;
        desc = cur_desc_mask[idx];
        if (prev_null && cur_null) return 0;
        if (prev_null) return cur_nulls_first ? -1 : 1;
        if (cur_null) return cur_nulls_first ? 1 : -1;
        if (prev < cur) return desc ? 1 : -1;
        if (cur < prev) return desc ? -1 : 1;
        return 0;
    endfunction

    function automatic result_t judge_row_order(row_keys_t keys, null_mask_t nulls);
        result_t verdict;
        int      active;
        int      step;
        logic    decided;
        verdict.order_error  = 1'b0;
        verdict.deciding_key = ALL_EQUAL;
        decided = 1'b0;
        active  = (cur_key_count > KEY_LIMIT) ? KEY_LIMIT : cur_key_count;
        if (seen_row) begin
            for (int i = 0; i < active; i++) begin
                if (!decided) begin
                    step = key_step_order(i, stored_keys[i], stored_nulls[i], keys[i], nulls[i]);
                    if (step != 0) begin
                        verdict.deciding_key = i[DEC_W-1:0];
                        verdict.order_error  = (step > 0);
                        decided = 1'b1;
                    end
                end
            end
        end
        stored_keys  = keys;
        stored_nulls = nulls;
        seen_row     = 1'b1;
        return verdict;
    endfunction

    // Driver: offers the next queued row, or idles at random, once the bus is free.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_verdicts.push_back(judge_row_order(offered_row.keys, offered_row.nulls));
            if (!s_tvalid || s_tready) begin
                if (rows_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    offered_row = rows_to_send.pop_front();
                    s_tdata  <= offered_row.keys;
                    s_tuser  <= offered_row.nulls;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each verdict and drives back-pressure, including long hold-offs.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected verdict %h with no row outstanding", m_tdata);
                end else begin
                    want = expected_verdicts.pop_front();
                    verdicts_seen++;
                    if (m_tdata[0] !== want.order_error || m_tdata[3:1] !== want.deciding_key
                        || m_tdata[7:4] !== 4'd0) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("verdict %0d: expected error=%0d key=%0d, got error=%0d key=%0d pad=%h",
                                     verdicts_seen, want.order_error, want.deciding_key,
                                     m_tdata[0], m_tdata[3:1], m_tdata[7:4]);
                    end
                    // Long stalls let the output fill so that s_tready has to drop.
                    if (verdicts_seen == 120 || verdicts_seen == 600)
                        holdoff_left = HOLDOFF_CYCLES;
                end
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic program_register(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= which;
        cfg_wdata <= value;
        case (which)
            REG_KEY_COUNT:       cur_key_count   = value[2:0];
            REG_DESCENDING_MASK: cur_desc_mask   = value[KEY_FIELDS-1:0];
            REG_NULLS_FIRST:     cur_nulls_first = value[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [2:0] count, input logic [3:0] desc, input logic nf);
        program_register(REG_KEY_COUNT, {1'b0, count});
        program_register(REG_DESCENDING_MASK, desc);
        program_register(REG_NULLS_FIRST, {3'd0, nf});
    endtask

    // Every queued row has produced its verdict; then allow the output pipe to settle.
    task automatic wait_drained();
        do @(posedge aclk); while (verdicts_seen != rows_issued);
        repeat (4) @(posedge aclk);
    endtask

    task automatic push_row(input logic [KEY_W-1:0] k0, input logic [KEY_W-1:0] k1,
                            input logic [KEY_W-1:0] k2, input logic [KEY_W-1:0] k3,
                            input null_mask_t nulls);
        row_t row;
        row.keys[0] = k0;
        row.keys[1] = k1;
        row.keys[2] = k2;
        row.keys[3] = k3;
        row.nulls   = nulls;
        rows_to_send.push_back(row);
        rows_issued++;
        last_row = row;
    endtask

    // Keys repeat the previous row often so that lower-priority keys get to decide.
    function automatic logic [KEY_W-1:0] next_key(logic [KEY_W-1:0] prev);
        logic [KEY_W-1:0] k;
        case ($urandom_range(11))
            0, 1, 2, 3, 4, 5: k = prev;
            6: k = prev + 64'd1;
            7: k = prev - 64'd1;
            8: k = 64'($urandom_range(6)) - 64'd3;
            9: k = $urandom_range(1) ? KEY_MIN : KEY_MAX;
            default: k = {$urandom, $urandom};
        endcase
        return k;
    endfunction

    task automatic push_random_row();
        null_mask_t nulls;
        if ($urandom_range(1)) begin
            nulls = last_row.nulls;
        end else begin
            for (int i = 0; i < KEY_FIELDS; i++)
                nulls[i] = ($urandom_range(4) == 0);
        end
        push_row(next_key(last_row.keys[0]), next_key(last_row.keys[1]),
                 next_key(last_row.keys[2]), next_key(last_row.keys[3]), nulls);
    endtask

    initial begin
        last_row.keys  = '0;
        last_row.nulls = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Ascending, nulls last: first row, ties, each key deciding, nulls either side.
        configure(3'd4, 4'b0000, 1'b0);
        push_row(KEY_MIN, KEY_MIN, KEY_MIN, KEY_MIN, 4'b0000);
        push_row(KEY_MIN, KEY_MIN, KEY_MIN, KEY_MIN, 4'b0000);
        push_row(KEY_MAX, KEY_MIN, KEY_MIN, KEY_MIN, 4'b0000);
        push_row(KEY_MAX, KEY_MAX, -64'sd1, 64'd0, 4'b0000);
        push_row(KEY_MAX, KEY_MAX, -64'sd2, 64'd0, 4'b0000);
        push_row(KEY_MAX, KEY_MAX, -64'sd2, -64'sd5, 4'b0000);
        push_row(KEY_MAX, KEY_MAX, -64'sd2, -64'sd5, 4'b0001);
        // Differing value hidden under a null on both sides.
        push_row(64'd7, KEY_MAX, -64'sd2, -64'sd5, 4'b0001);
        push_row(64'd0, KEY_MAX, -64'sd2, -64'sd5, 4'b0000);
        wait_drained();

        // Descending with nulls first; the stored row carries over the change.
        configure(3'd4, 4'b1111, 1'b1);
        push_row(-64'sd1, KEY_MAX, -64'sd2, -64'sd5, 4'b0000);
        push_row(64'd5, KEY_MAX, -64'sd2, -64'sd5, 4'b0000);
        push_row(64'd5, KEY_MAX, -64'sd2, -64'sd5, 4'b0001);
        push_row(64'd5, KEY_MAX, -64'sd2, -64'sd5, 4'b0000);
        push_row(64'd5, KEY_MAX, -64'sd2, -64'sd5, 4'b1111);
        push_row(KEY_MIN, 64'd1, KEY_MAX, 64'd9, 4'b1111);
        wait_drained();

        // No keys in use: nothing is compared.
        configure(3'd0, 4'b0101, 1'b0);
        push_row(KEY_MAX, KEY_MIN, KEY_MAX, KEY_MIN, 4'b0000);
        push_row(KEY_MIN, KEY_MAX, KEY_MIN, KEY_MAX, 4'b1010);
        wait_drained();

        // Key count above the field count saturates.
        configure(3'd7, 4'b1010, 1'b0);
        push_row(KEY_MIN, KEY_MAX, KEY_MIN, KEY_MAX, 4'b1010);
        push_row(KEY_MIN, KEY_MAX, KEY_MIN, KEY_MAX, 4'b0000);
        push_row(KEY_MIN, KEY_MAX, KEY_MIN, KEY_MIN, 4'b0000);
        push_row(KEY_MIN, KEY_MAX, KEY_MIN, 64'd0, 4'b0000);
        wait_drained();

        configure(3'd5, 4'b0110, 1'b1);
        push_row(KEY_MIN, KEY_MAX, KEY_MAX, 64'd0, 4'b0000);
        push_row(KEY_MIN, KEY_MAX, KEY_MAX, 64'd0, 4'b0100);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            configure(($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4)),
                      4'($urandom_range(15)), 1'($urandom_range(1)));
            case (phase % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            repeat (PHASE_ROWS) push_random_row();
            wait_drained();
        end

        if (fail_count == 0 && expected_verdicts.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
